// ===== rtl/key_matrix_six_key_rollover_unit_defines.svh =====
// Assertion macros used by the key matrix scanner checker.
`ifndef KEY_MATRIX_SIX_KEY_ROLLOVER_UNIT_DEFINES_SVH
`define KEY_MATRIX_SIX_KEY_ROLLOVER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KMSK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KMSK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kmsk_pkg.sv =====
// Types and constants shared by the key matrix rollover scanner.
`default_nettype none
package kmsk_pkg;

	localparam int TIME_W            = 32;
	localparam int MAP_W             = 20;
	localparam int SLOT_OUT_W        = 5;
	localparam int SLOT_OUTS         = 6;
	localparam int CMD_W             = 2;
	localparam int ROW_IN_W          = 3;
	localparam logic [TIME_W-1:0] DEBOUNCE_RESET_US = 32'd20000;

	typedef enum logic [CMD_W-1:0] {
		CMD_POLL    = 2'd0,
		CMD_PRESS   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_BOTH    = 2'd3
	} kmsk_cmd_t;

	// Operation applied to the slot bank for one key
	typedef enum logic [1:0] {
		KEY_NOP,
		KEY_ADD,
		KEY_DEL
	} kmsk_key_op_t;

endpackage
`default_nettype wire

// ===== rtl/key_matrix_six_key_rollover_unit.sv =====
// Key matrix scanner with per-row debounce and six-key rollover slots.
//
// Input channel: in_valid / in_stall carry command, row_index, time_us and
// pressed_map. One item is taken when in_valid is high and in_stall low;
// in_stall stays high until that item's result is in the output register.
// Output channel: out_valid / out_stall carry accepted and slot_0..slot_5,
// the slot contents after the item. A result waits in the output register
// while out_stall is high; the next item is taken meanwhile and finishes
// its walk, then holds until the register frees.
// Config: cfg_valid / cfg_ready write debounce_interval_us (cfg_ready is
// always high); write only while no item is in flight.
// Each item walks the K = ROW_COUNT * COLUMN_COUNT keys, one key per cycle
// through the shared slot bank: a poll or single-edge item walks them once,
// a press-and-release item twice and a dropped item not at all. in_stall
// drops right after the result is loaded into the output register.
// Reset: slots empty, row times zero, interval 20000 us, channels idle.
`default_nettype none
module key_matrix_six_key_rollover_unit #(
	parameter int ROW_COUNT    = 5,
	parameter int COLUMN_COUNT = 4,
	parameter int SLOT_COUNT   = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [kmsk_pkg::TIME_W-1:0]     cfg_data,
	// input items
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [kmsk_pkg::CMD_W-1:0]      command,
	input  wire logic [kmsk_pkg::ROW_IN_W-1:0]   row_index,
	input  wire logic [kmsk_pkg::TIME_W-1:0]     time_us,
	input  wire logic [kmsk_pkg::MAP_W-1:0]      pressed_map,
	// result items
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 accepted,
	output logic [kmsk_pkg::SLOT_OUT_W-1:0]      slot_0,
	output logic [kmsk_pkg::SLOT_OUT_W-1:0]      slot_1,
	output logic [kmsk_pkg::SLOT_OUT_W-1:0]      slot_2,
	output logic [kmsk_pkg::SLOT_OUT_W-1:0]      slot_3,
	output logic [kmsk_pkg::SLOT_OUT_W-1:0]      slot_4,
	output logic [kmsk_pkg::SLOT_OUT_W-1:0]      slot_5
);
	import kmsk_pkg::*;

	localparam int KEY_COUNT = ROW_COUNT * COLUMN_COUNT;
	localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int COL_W     = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
	localparam int POS_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int CODE_W    = $clog2(KEY_COUNT + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PASS_POLL,
		PASS_PRESS,
		PASS_RELEASE
	} pass_t;

	state_t                state_q;
	pass_t                 pass_q;
	kmsk_cmd_t             cmd_q;
	logic [ROW_W-1:0]      row_sel_q;
	logic [TIME_W-1:0]     time_q;
	logic [MAP_W-1:0]      map_q;
	logic                  acc_q;
	logic [ROW_W-1:0]      row_cnt_q;
	logic [COL_W-1:0]      col_cnt_q;
	logic [POS_W-1:0]      pos_q;
	logic                  out_valid_q;
	logic                  out_acc_q;
	logic [SLOT_OUT_W-1:0] out_slot_q [SLOT_OUTS];

	logic                  in_take;
	logic                  db_pass;
	logic                  db_commit;
	logic [KEY_COUNT-1:0]  key_map;
	logic                  key_down;
	logic                  last_row;
	logic                  last_key;
	kmsk_key_op_t          key_op;
	logic [CODE_W-1:0]     key_code;
	logic [CODE_W-1:0]     slots [SLOT_COUNT];
	logic [SLOT_OUT_W-1:0] slot_view [SLOT_OUTS];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && (state_q == ST_IDLE);

	// keys past the snapshot width read as released
	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
		if (k < MAP_W) begin : g_in
			assign key_map[k] = map_q[k];
		end else begin : g_out
			assign key_map[k] = 1'b0;
		end
	end

	assign key_down = key_map[pos_q];
	assign key_code = CODE_W'(pos_q) + CODE_W'(1);
	assign last_row = (row_cnt_q == ROW_W'(ROW_COUNT - 1));
	assign last_key = last_row && (col_cnt_q == COL_W'(COLUMN_COUNT - 1));

	always_comb begin
		key_op = KEY_NOP;
		if (state_q == ST_WALK) begin
			if (key_down && (pass_q != PASS_RELEASE)) begin
				key_op = KEY_ADD;
			end else if (!key_down && (pass_q != PASS_PRESS)) begin
				key_op = KEY_DEL;
			end
		end
	end

	assign db_commit = (state_q == ST_CHECK) && db_pass;

	kmsk_debounce #(
		.ROW_COUNT(ROW_COUNT)
	) u_debounce (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid),
		.cfg_data(cfg_data),
		.row     (row_sel_q),
		.now     (time_q),
		.commit  (db_commit),
		.pass    (db_pass)
	);

	kmsk_slot_bank #(
		.SLOT_COUNT(SLOT_COUNT),
		.CODE_W    (CODE_W)
	) u_slots (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (key_op),
		.code  (key_code),
		.slots (slots)
	);

	for (genvar i = 0; i < SLOT_OUTS; i++) begin : g_view
		if (i < SLOT_COUNT) begin : g_slot
			assign slot_view[i] = SLOT_OUT_W'(slots[i]);
		end else begin : g_none
			assign slot_view[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= PASS_POLL;
			cmd_q       <= CMD_POLL;
			row_sel_q   <= '0;
			time_q      <= '0;
			map_q       <= '0;
			acc_q       <= 1'b0;
			row_cnt_q   <= '0;
			col_cnt_q   <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
			for (int i = 0; i < SLOT_OUTS; i++) begin
				out_slot_q[i] <= '0;
			end
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						cmd_q     <= kmsk_cmd_t'(command);
						// out-of-range rows debounce as row 0
						row_sel_q <= (32'(row_index) < ROW_COUNT) ? ROW_W'(row_index) : '0;
						time_q    <= time_us;
						map_q     <= pressed_map;
						acc_q     <= 1'b1;
						row_cnt_q <= '0;
						col_cnt_q <= '0;
						pos_q     <= '0;
						pass_q    <= PASS_POLL;
						state_q   <= (kmsk_cmd_t'(command) == CMD_POLL) ? ST_WALK : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (db_pass) begin
						pass_q  <= (cmd_q inside {CMD_PRESS, CMD_BOTH}) ? PASS_PRESS
						                                                : PASS_RELEASE;
						state_q <= ST_WALK;
					end else begin
						acc_q   <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_WALK: begin
					// column-major walk: rows inside each column
					if (last_key) begin
						row_cnt_q <= '0;
						col_cnt_q <= '0;
						pos_q     <= '0;
						if ((pass_q == PASS_PRESS) && (cmd_q == CMD_BOTH)) begin
							pass_q <= PASS_RELEASE;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (last_row) begin
						row_cnt_q <= '0;
						col_cnt_q <= col_cnt_q + COL_W'(1);
						pos_q     <= POS_W'(col_cnt_q) + POS_W'(1);
					end else begin
						row_cnt_q <= row_cnt_q + ROW_W'(1);
						pos_q     <= pos_q + POS_W'(COLUMN_COUNT);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_acc_q   <= acc_q;
						for (int i = 0; i < SLOT_OUTS; i++) begin
							out_slot_q[i] <= slot_view[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = out_acc_q;
	assign slot_0    = out_slot_q[0];
	assign slot_1    = out_slot_q[1];
	assign slot_2    = out_slot_q[2];
	assign slot_3    = out_slot_q[3];
	assign slot_4    = out_slot_q[4];
	assign slot_5    = out_slot_q[5];

endmodule
`default_nettype wire

// ===== rtl/kmsk_debounce.sv =====
// Per-row event time store and debounce compare.
`default_nettype none
module kmsk_debounce #(
	parameter int ROW_COUNT = 5,
	localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [kmsk_pkg::TIME_W-1:0] cfg_data,
	input  wire logic [ROW_W-1:0]            row,
	input  wire logic [kmsk_pkg::TIME_W-1:0] now,
	input  wire logic                        commit,
	output logic                             pass
);
	import kmsk_pkg::*;

	logic [TIME_W-1:0] interval_q;
	logic [TIME_W-1:0] row_time_q [ROW_COUNT];
	logic [TIME_W-1:0] elapsed;

	// wrapping difference against the row's last accepted event
	assign elapsed = now - row_time_q[row];
	assign pass    = !(elapsed < interval_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= DEBOUNCE_RESET_US;
			for (int r = 0; r < ROW_COUNT; r++) begin
				row_time_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_data;
			end
			if (commit) begin
				row_time_q[row] <= now;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kmsk_slot_bank.sv =====
// Rollover slot bank: applies one key add or remove per cycle.
`default_nettype none
module kmsk_slot_bank #(
	parameter int SLOT_COUNT = 6,
	parameter int CODE_W     = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire kmsk_pkg::kmsk_key_op_t op,
	input  wire logic [CODE_W-1:0]      code,
	output logic      [CODE_W-1:0]      slots [SLOT_COUNT]
);
	import kmsk_pkg::*;

	logic [CODE_W-1:0]     slot_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] match;
	logic [SLOT_COUNT-1:0] add_sel;
	logic                  hit;

	always_comb begin
		logic seen;
		seen = 1'b0;
		hit  = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match[i]   = (slot_q[i] == code);
			hit        = hit | match[i];
			// first empty slot only
			add_sel[i] = !seen && (slot_q[i] == '0);
			seen       = seen | (slot_q[i] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			case (op)
				KEY_ADD: begin
					if (!hit) begin
						for (int i = 0; i < SLOT_COUNT; i++) begin
							if (add_sel[i]) begin
								slot_q[i] <= code;
							end
						end
					end
				end
				KEY_DEL: begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (match[i]) begin
							slot_q[i] <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slots[i] = slot_q[i];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kmsk_checker.sv =====
// Port-level checks for the key matrix scanner, bound to the top level.
`default_nettype none
`include "key_matrix_six_key_rollover_unit_defines.svh"
module kmsk_checker #(
	parameter int ROW_COUNT    = 5,
	parameter int COLUMN_COUNT = 4
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [kmsk_pkg::SLOT_OUT_W-1:0] slot_0,
	input wire logic [kmsk_pkg::SLOT_OUT_W-1:0] slot_1,
	input wire logic [kmsk_pkg::SLOT_OUT_W-1:0] slot_2
);
	import kmsk_pkg::*;

	localparam int KEY_COUNT = ROW_COUNT * COLUMN_COUNT;
	// codes fit the output width only for small matrices
	localparam bit CODES_EXACT = (KEY_COUNT < (1 << SLOT_OUT_W));

	`KMSK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid,
		"result dropped while stalled")
	`KMSK_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall,
		"new item taken before the previous one finished")
	`KMSK_ASSERT_NOW(a_code_range, out_valid && CODES_EXACT,
		(32'(slot_0) <= KEY_COUNT) && (32'(slot_1) <= KEY_COUNT),
		"slot holds a code beyond the matrix")
	`KMSK_ASSERT_NOW(a_no_dup, out_valid && CODES_EXACT && (slot_0 != '0),
		(slot_0 != slot_1) && (slot_0 != slot_2),
		"key held in two slots")

endmodule

bind key_matrix_six_key_rollover_unit kmsk_checker #(
	.ROW_COUNT   (ROW_COUNT),
	.COLUMN_COUNT(COLUMN_COUNT)
) u_kmsk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.slot_0   (slot_0),
	.slot_1   (slot_1),
	.slot_2   (slot_2)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the key matrix six-key rollover scanner.
`timescale 1ns / 100ps
module testbench;
	import kmsk_pkg::*;

	localparam int ROWS        = 5;
	localparam int COLS        = 4;
	localparam int SLOTS       = 6;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 50;

	typedef struct packed {
		logic                              accepted;
		logic [SLOTS-1:0][SLOT_OUT_W-1:0]  slot;
	} slot_view_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [TIME_W-1:0]       cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        scan_cmd = CMD_POLL;
	logic [ROW_IN_W-1:0]     scan_row = '0;
	logic [TIME_W-1:0]       scan_time = '0;
	logic [MAP_W-1:0]        scan_map = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    accepted;
	logic [SLOT_OUT_W-1:0]   slot_0, slot_1, slot_2, slot_3, slot_4, slot_5;

	// predictor state
	logic [SLOT_OUT_W-1:0]   held_slot [SLOTS] = '{default: '0};
	logic [TIME_W-1:0]       row_stamp [ROWS] = '{default: '0};
	logic [TIME_W-1:0]       debounce_us = DEBOUNCE_RESET_US;

	slot_view_t              expected_slot_views [$];
	slot_view_t              want_view;
	logic [SLOTS-1:0][SLOT_OUT_W-1:0] got_slots;
	int                      failures = 0;
	bit                      calm = 1'b0;

	// generator state for realistic typing
	logic [MAP_W-1:0]        hand_map = '0;
	logic [TIME_W-1:0]       clock_us = '0;

	key_matrix_six_key_rollover_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (scan_cmd),
		.row_index   (scan_row),
		.time_us     (scan_time),
		.pressed_map (scan_map),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.slot_0      (slot_0),
		.slot_1      (slot_1),
		.slot_2      (slot_2),
		.slot_3      (slot_3),
		.slot_4      (slot_4),
		.slot_5      (slot_5)
	);

	assign got_slots = {slot_5, slot_4, slot_3, slot_2, slot_1, slot_0};

	always #5 clk = ~clk;

	// Column-major key walk against the slot bank.
	function automatic void walk_keys(logic [MAP_W-1:0] map, bit do_add, bit do_del);
		int pos;
		int free_slot;
		bit held;
		logic [SLOT_OUT_W-1:0] code;
		for (int col = 0; col < COLS; col++) begin
			for (int r = 0; r < ROWS; r++) begin
				pos = r * COLS + col;
				code = SLOT_OUT_W'(pos + 1);
				if (map[pos]) begin
					if (do_add) begin
						held = 1'b0;
						free_slot = -1;
						for (int s = 0; s < SLOTS; s++) begin
							if (held_slot[s] == code)
								held = 1'b1;
							if (held_slot[s] == '0 && free_slot < 0)
								free_slot = s;
						end
						if (!held && free_slot >= 0)
							held_slot[free_slot] = code;
					end
				end else if (do_del) begin
					for (int s = 0; s < SLOTS; s++)
						if (held_slot[s] == code)
							held_slot[s] = '0;
				end
			end
		end
	endfunction

	function automatic slot_view_t predict_rollover(kmsk_cmd_t cmd, logic [ROW_IN_W-1:0] row,
			logic [TIME_W-1:0] now, logic [MAP_W-1:0] map);
		slot_view_t res;
		int r;
		logic [TIME_W-1:0] age;
		res.accepted = 1'b1;
		if (cmd == CMD_POLL) begin
			walk_keys(map, 1'b1, 1'b1);
		end else begin
			r = (row >= ROWS) ? 0 : int'(row);
			age = now - row_stamp[r];
			if (age < debounce_us) begin
				res.accepted = 1'b0;
			end else begin
				row_stamp[r] = now;
				if (cmd == CMD_PRESS || cmd == CMD_BOTH)
					walk_keys(map, 1'b1, 1'b0);
				if (cmd == CMD_RELEASE || cmd == CMD_BOTH)
					walk_keys(map, 1'b0, 1'b1);
			end
		end
		for (int s = 0; s < SLOTS; s++)
			res.slot[s] = held_slot[s];
		return res;
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_slot_views.size() == 0) begin
				$error("result item with no scan pending");
				failures++;
			end else begin
				want_view = expected_slot_views.pop_front();
				if (want_view.accepted !== accepted) begin
					$error("accepted: expected %0d, actual %0d", want_view.accepted, accepted);
					failures++;
				end
				for (int s = 0; s < SLOTS; s++) begin
					if (want_view.slot[s] !== got_slots[s]) begin
						$error("slot_%0d: expected %0d, actual %0d", s, want_view.slot[s],
							got_slots[s]);
						failures++;
					end
				end
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 15);

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL key_matrix_six_key_rollover_unit");
		$finish;
	end

	// Called at a falling edge; returns at a falling edge.
	task automatic send_scan(kmsk_cmd_t cmd, logic [ROW_IN_W-1:0] row, logic [TIME_W-1:0] now,
			logic [MAP_W-1:0] map);
		if (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		scan_cmd <= cmd;
		scan_row <= row;
		scan_time <= now;
		scan_map <= map;
		do
			@(posedge clk);
		while (in_stall);
		expected_slot_views.push_back(predict_rollover(cmd, row, now, map));
		// withdraw the taken item while the block is still busy with it
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		while (expected_slot_views.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_interval(logic [TIME_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		debounce_us = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Typing-like scan: mostly a few keys change, time advances by about the interval or a fraction of it.
	// A share of items is pure noise.
	task automatic random_scan(int noise_pct);
		logic [MAP_W-1:0] prev;
		logic [MAP_W-1:0] added;
		logic [MAP_W-1:0] removed;
		logic [TIME_W-1:0] step;
		kmsk_cmd_t cmd;
		int pick;
		int idx;
		if ($urandom_range(0, 99) < noise_pct) begin
			send_scan(kmsk_cmd_t'($urandom_range(0, 3)), ROW_IN_W'($urandom_range(0, 7)),
				$urandom, MAP_W'($urandom));
		end else begin
			prev = hand_map;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				hand_map = '1;
			else if (pick < 10)
				hand_map = '0;
			else if (pick < 20)
				hand_map = MAP_W'($urandom);
			else
				for (int k = $urandom_range(1, 3); k > 0; k--) begin
					idx = $urandom_range(0, MAP_W - 1);
					hand_map[idx] = ~hand_map[idx];
				end
			added = hand_map & ~prev;
			removed = prev & ~hand_map;
			if ($urandom_range(0, 99) < 20)
				cmd = CMD_POLL;
			else if (added != '0 && removed != '0)
				cmd = CMD_BOTH;
			else if (removed != '0)
				cmd = CMD_RELEASE;
			else
				cmd = CMD_PRESS;
			if (debounce_us == '0) begin
				step = $urandom_range(0, 5000);
			end else begin
				step = debounce_us >> $urandom_range(0, 3);
				step = step + $urandom_range(0, 40) - 20;
			end
			clock_us = clock_us + step;
			send_scan(cmd, ROW_IN_W'($urandom_range(0, ROWS - 1)), clock_us, hand_map);
		end
	endtask

	task automatic test_directed_cases();
		send_scan(CMD_POLL, 0, 0, '0);
		send_scan(CMD_PRESS, 0, 5, '1);              // too soon after reset
		send_scan(CMD_POLL, 3, 32'hFFFF_FFFF, '1);   // more keys than slots
		send_scan(CMD_POLL, 1, 7, '1);               // already held, no duplicates
		send_scan(CMD_POLL, 2, 9, '0);
		send_scan(CMD_PRESS, 0, 20000, 20'h80000);   // exactly the interval
		send_scan(CMD_PRESS, 5, 20001, '1);          // out-of-range row hits row 0
		send_scan(CMD_PRESS, 7, 40000, 20'h00001);
		send_scan(CMD_RELEASE, 4, 32'hFFFF_FFFF, '1);
		send_scan(CMD_RELEASE, 4, 32'hFFFF_FFFF, '0); // zero age, dropped
		send_scan(CMD_BOTH, 1, 32'hFFFF_FFFF, 20'h00001);
		send_scan(CMD_PRESS, 1, 100, '1);            // wrapped age too small
		send_scan(CMD_PRESS, 1, 19999, 20'hAAAAA);   // wrapped age equals interval
		send_scan(CMD_RELEASE, 2, 30000, 20'h55555);
		send_scan(CMD_BOTH, 3, 50000, 20'h0F0F0);
		send_scan(CMD_PRESS, 6, 90000, '0);
		send_scan(CMD_POLL, 7, 1, 20'h55555);
		send_scan(CMD_BOTH, 2, 32'h8000_0000, '1);
		send_scan(CMD_RELEASE, 3, 32'hC000_0000, '0);
		send_scan(CMD_POLL, 0, 0, '0);
		go_quiet();
	endtask

	task automatic test_interval_extremes();
		logic [TIME_W-1:0] settings [6];
		settings = '{32'd0, 32'd1, 32'hFFFF_FFFF, $urandom, $urandom_range(100, 60000),
			DEBOUNCE_RESET_US};
		for (int k = 0; k < 6; k++) begin
			write_interval(settings[k]);
			repeat (120) random_scan(10);
			go_quiet();
		end
	endtask

	// Sender drains the block between bursts.
	task automatic test_drain_pauses();
		clock_us = 32'hFFFF_0000;
		for (int k = 0; k < 10; k++) begin
			repeat (30) random_scan(10);
			go_quiet();
		end
	endtask

	task automatic test_calm_burst();
		calm = 1'b1;
		write_interval($urandom_range(0, 30000));
		repeat (250) random_scan(5);
		go_quiet();
		calm = 1'b0;
	endtask

	task automatic test_mixed_traffic();
		write_interval($urandom_range(1000, 25000));
		repeat (420) random_scan(20);
		go_quiet();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_interval_extremes();
		test_drain_pauses();
		test_calm_burst();
		test_mixed_traffic();
		repeat (SETTLE) @(posedge clk);
		if (failures == 0)
			$display("PASS key_matrix_six_key_rollover_unit");
		else
			$display("FAIL key_matrix_six_key_rollover_unit");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kmsk_pkg.sv
rtl/kmsk_debounce.sv
rtl/kmsk_slot_bank.sv
rtl/key_matrix_six_key_rollover_unit.sv
rtl/kmsk_checker.sv
verif/testbench.sv
